// ----- hdl/bjb_pkg.sv -----
// bjb_pkg: shared types and constants of the byte jitter buffer
// used by bjb_core, byte_jitter_buffer_top and bjb_checker; no dependencies
package bjb_pkg;

  // field widths fixed by the item format
  localparam int LEN_W     = 12;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 32;
  localparam int CAP_FLD_W = 13;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic [ADDR_W-3:0]    REG_CAPACITY = '0;
  localparam logic [CAP_FLD_W-1:0] CAP_RESET    = 13'd4096;

  // input opcodes
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_PULL   = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_PULL   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // one result item
  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] out_byte;
    logic              accepted;
    logic              padded;
    logic              last;
    logic [LEN_W-1:0]  fill_bytes;
    logic [LEN_W-1:0]  free_bytes;
    logic [CNT_W-1:0]  underrun_total;
    logic [CNT_W-1:0]  overrun_total;
    logic [CNT_W-1:0]  pushed_total;
    logic [CNT_W-1:0]  pulled_total;
  } res_t;

endpackage

// ----- hdl/bjb_ram.sv -----
// bjb_ram: byte store of the ring, one write port and one read port
// read data registered; no dependencies
module bjb_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/bjb_core.sv -----
// bjb_core: ring pointers, chunk admission, pull sequencer, counters, result register
// depends on bjb_pkg and bjb_ram
module bjb_core #(
  parameter int RING_DEPTH = 4096,
  parameter int MAX_PULL   = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [$clog2(RING_DEPTH):0]       cap_i,
  input  logic                              clr_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        opcode_i,
  input  logic [7:0]                        in_byte_i,
  input  logic                              chunk_first_i,
  input  logic [11:0]                       length_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bjb_pkg::res_t                     res_o
);
  import bjb_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam int CW = PW + 1;
  localparam int NW = $clog2(MAX_PULL + 1);
  localparam int XW = (PW > LEN_W) ? PW : LEN_W;

  typedef enum logic [1:0] {S_IDLE, S_PULL, S_DATA} state_e;

  state_e            state_q;
  logic [PW-1:0]     wp_q, rp_q, fill_q;
  logic [LEN_W-1:0]  rem_q;
  logic              rej_q;
  logic [CNT_W-1:0]  under_q, over_q, pushed_q, pulled_q;
  logic [NW-1:0]     n_q, take_q, k_q;
  logic              ov_q;
  res_t              res_q;

  logic              slot_free, accept;
  logic [CW-1:0]     cap_m1, wp_nx, rp_nx;
  logic [PW-1:0]     free_w, wp_wrap, rp_wrap;
  logic [NW-1:0]     n_w, take_w, k_nx;
  logic              last_k;
  logic              store, ovf, rej_nx;
  logic [LEN_W-1:0]  rem_nx;
  logic              we, re;
  logic [7:0]        rdata;
  res_t              res_d;
  logic              res_load;

  assign cap_m1  = cap_i - CW'(1);
  assign free_w  = cap_m1[PW-1:0] - fill_q;
  assign wp_nx   = {1'b0, wp_q} + CW'(1);
  assign rp_nx   = {1'b0, rp_q} + CW'(1);
  assign wp_wrap = (wp_nx == cap_i) ? '0 : wp_nx[PW-1:0];
  assign rp_wrap = (rp_nx == cap_i) ? '0 : rp_nx[PW-1:0];

  assign slot_free  = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  // pull count clamp and real bytes available
  assign n_w    = (length_i > LEN_W'(MAX_PULL)) ? NW'(MAX_PULL) : NW'(length_i);
  assign take_w = (XW'(fill_q) < XW'(n_w)) ? NW'(fill_q) : n_w;
  assign k_nx   = k_q + NW'(1);
  assign last_k = (k_nx == n_q);

  // chunk admission on the first byte, countdown on the rest
  always_comb begin
    store  = 1'b0;
    ovf    = 1'b0;
    rej_nx = rej_q;
    rem_nx = rem_q;
    if (chunk_first_i) begin
      ovf    = XW'(length_i) > XW'(free_w);
      rej_nx = ovf;
      if (length_i == '0) begin
        rem_nx = '0;
      end else begin
        rem_nx = length_i - LEN_W'(1);
        store  = !ovf;
      end
    end else if (rem_q != '0) begin
      rem_nx = rem_q - LEN_W'(1);
      store  = !rej_q;
    end
  end

  assign we = accept && (opcode_i == OP_PUSH) && store && (free_w != '0);
  assign re = (state_q == S_PULL) && slot_free && (k_q < take_q);

  // next result item and when it is loaded
  always_comb begin
    res_d    = '0;
    res_load = 1'b0;
    if (!clr_i) begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && (opcode_i == OP_PUSH)) begin
            res_d.kind     = KIND_ACK;
            res_d.accepted = we;
            res_d.last     = 1'b1;
            res_load       = 1'b1;
          end else if (accept && (opcode_i == OP_STATUS)) begin
            res_d.kind           = KIND_STATUS;
            res_d.last           = 1'b1;
            res_d.fill_bytes     = LEN_W'(fill_q);
            res_d.free_bytes     = LEN_W'(free_w);
            res_d.underrun_total = under_q;
            res_d.overrun_total  = over_q;
            res_d.pushed_total   = pushed_q;
            res_d.pulled_total   = pulled_q;
            res_load             = 1'b1;
          end
        end
        S_PULL: begin
          if (slot_free && !re) begin
            res_d.kind   = KIND_PULL;
            res_d.padded = 1'b1;
            res_d.last   = last_k;
            res_load     = 1'b1;
          end
        end
        S_DATA: begin
          res_d.kind     = KIND_PULL;
          res_d.out_byte = rdata;
          res_d.last     = last_k;
          res_load       = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  bjb_ram #(
    .DEPTH (RING_DEPTH),
    .AW    (PW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (in_byte_i),
    .re_i    (re),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wp_q     <= '0;
      rp_q     <= '0;
      fill_q   <= '0;
      rem_q    <= '0;
      rej_q    <= 1'b0;
      under_q  <= '0;
      over_q   <= '0;
      pushed_q <= '0;
      pulled_q <= '0;
      n_q      <= '0;
      take_q   <= '0;
      k_q      <= '0;
      ov_q     <= 1'b0;
      res_q    <= '0;
    end else begin
      if (res_load) begin
        res_q <= res_d;
        ov_q  <= 1'b1;
      end else if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (clr_i) begin
        wp_q   <= '0;
        rp_q   <= '0;
        fill_q <= '0;
        rem_q  <= '0;
        rej_q  <= 1'b0;
      end else begin
        unique case (state_q)
          S_IDLE: begin
            if (accept) begin
              case (opcode_i)
                OP_PUSH: begin
                  rem_q <= rem_nx;
                  rej_q <= rej_nx;
                  if (chunk_first_i && ovf) begin
                    over_q <= over_q + CNT_W'(1);
                  end
                  if (we) begin
                    wp_q     <= wp_wrap;
                    fill_q   <= fill_q + PW'(1);
                    pushed_q <= pushed_q + CNT_W'(1);
                  end
                end
                OP_PULL: begin
                  n_q    <= n_w;
                  take_q <= take_w;
                  k_q    <= '0;
                  if (take_w < n_w) begin
                    under_q <= under_q + CNT_W'(1);
                  end
                  if (n_w != '0) begin
                    state_q <= S_PULL;
                  end
                end
                default: begin
                end
              endcase
            end
          end
          S_PULL: begin
            if (slot_free) begin
              if (re) begin
                // real byte: read issued now, data lands next cycle
                rp_q     <= rp_wrap;
                fill_q   <= fill_q - PW'(1);
                pulled_q <= pulled_q + CNT_W'(1);
                state_q  <= S_DATA;
              end else begin
                k_q <= k_nx;
                if (last_k) begin
                  state_q <= S_IDLE;
                end
              end
            end
          end
          S_DATA: begin
            k_q     <= k_nx;
            state_q <= last_k ? S_IDLE : S_PULL;
          end
          default: begin
            state_q <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign out_valid_o = ov_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/byte_jitter_buffer_top.sv -----
// byte_jitter_buffer_top: byte ring buffer with chunk admission and padded pulls
// depends on bjb_pkg and bjb_core (which holds bjb_ram)
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ----------------------------------------
//  in        sink       in_valid_i / in_ready_o    opcode, in_byte, chunk_first, length
//  out       source     out_valid_o / out_ready_i  kind, out_byte, accepted, padded, last,
//                                                  fill/free, four wrapping counters
//  cfg       APB slave  psel/penable/pwrite        ring_capacity at byte address 0
//
// a push or status item's result sits in the output register next cycle
// a pull of n bytes (n clamped to MAX_PULL) gives its real bytes first, each read from the
//   byte store in S_PULL and loaded as a result in S_DATA, then its padding bytes, each
//   loaded directly from S_PULL
// a new item is taken once the previous item's last result is loaded and the output
//   register is free or being emptied; a stalled output holds the sequencer
// reset clears pointers, chunk state and counters; the byte store is not cleared
// a capacity write empties the ring and keeps the counters
module byte_jitter_buffer_top #(
  parameter int RING_DEPTH = 4096,
  parameter int MAX_PULL   = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bjb_pkg::ADDR_W-1:0]    paddr,
  input  logic [bjb_pkg::DATA_W-1:0]    pwdata,
  output logic [bjb_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic [7:0]                    in_byte_i,
  input  logic                          chunk_first_i,
  input  logic [11:0]                   length_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    out_byte_o,
  output logic                          accepted_o,
  output logic                          padded_o,
  output logic                          last_o,
  output logic [11:0]                   fill_bytes_o,
  output logic [11:0]                   free_bytes_o,
  output logic [31:0]                   underrun_total_o,
  output logic [31:0]                   overrun_total_o,
  output logic [31:0]                   pushed_total_o,
  output logic [31:0]                   pulled_total_o
);
  import bjb_pkg::*;

  localparam int CW = $clog2(RING_DEPTH) + 1;

  logic [CAP_FLD_W-1:0] cap_raw_q;
  logic [CW-1:0]        cap_eff;
  logic                 cap_hit;
  logic                 cap_wr;
  res_t                 res;

  // register decode; only index zero exists
  assign cap_hit = (paddr[ADDR_W-1:2] == REG_CAPACITY);
  assign cap_wr  = psel && penable && pwrite && cap_hit;
  assign pready  = 1'b1;
  assign prdata  = cap_hit ? DATA_W'(cap_raw_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_raw_q <= CAP_RESET;
    end else if (cap_wr) begin
      cap_raw_q <= pwdata[CAP_FLD_W-1:0];
    end
  end

  // capacity in use, clamped to [2, RING_DEPTH]
  always_comb begin
    if (cap_raw_q < CAP_FLD_W'(2)) begin
      cap_eff = CW'(2);
    end else if (32'(cap_raw_q) > 32'(RING_DEPTH)) begin
      cap_eff = CW'(RING_DEPTH);
    end else begin
      cap_eff = CW'(cap_raw_q);
    end
  end

  bjb_core #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_PULL   (MAX_PULL)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cap_i         (cap_eff),
    .clr_i         (cap_wr),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .in_byte_i     (in_byte_i),
    .chunk_first_i (chunk_first_i),
    .length_i      (length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .res_o         (res)
  );

  // result fields out to their ports
  assign kind_o           = res.kind;
  assign out_byte_o       = res.out_byte;
  assign accepted_o       = res.accepted;
  assign padded_o         = res.padded;
  assign last_o           = res.last;
  assign fill_bytes_o     = res.fill_bytes;
  assign free_bytes_o     = res.free_bytes;
  assign underrun_total_o = res.underrun_total;
  assign overrun_total_o  = res.overrun_total;
  assign pushed_total_o   = res.pushed_total;
  assign pulled_total_o   = res.pulled_total;

endmodule

// ----- hdl/bjb_checker.sv -----
// bjb_checker: port-level assertions on the byte jitter buffer results
// depends on bjb_pkg; bound to byte_jitter_buffer_top below
module bjb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] out_byte_o,
  input logic       accepted_o,
  input logic       padded_o,
  input logic       last_o
);
  import bjb_pkg::*;

  // padding bytes are silence and only come from pulls
  a_pad_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && padded_o |-> kind_o == KIND_PULL && out_byte_o == 8'd0)
    else $error("padding item not a silent pulled byte");

  // only a push acknowledge reports a stored byte
  a_acc_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> kind_o == KIND_ACK && !padded_o)
    else $error("accepted flag on a non-acknowledge item");

  // acknowledges and status reports are single items
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_PULL |-> last_o)
    else $error("single-result item without last");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(kind_o)
      && $stable(last_o))
    else $error("result changed while stalled");

endmodule

bind byte_jitter_buffer_top bjb_checker u_bjb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .out_byte_o  (out_byte_o),
  .accepted_o  (accepted_o),
  .padded_o    (padded_o),
  .last_o      (last_o)
);
